// ===== rtl/latency_log_priority_macros.svh =====
`ifndef LATENCY_LOG_PRIORITY_MACROS_SVH
`define LATENCY_LOG_PRIORITY_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LLP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("latency_log_priority: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LLP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("latency_log_priority: next-cycle check failed");

`endif

// ===== rtl/llp_pkg.sv =====
`default_nettype none

package llp_pkg;

  // Latency bits that take part in the logarithm
  localparam int LAT_BITS    = 32;
  localparam int MAX_SAMPLES = 200;

  // Normalizer works on a power-of-two word of at least 32 bits
  localparam int NORM_W      = (LAT_BITS > 32) ? 64 : 32;
  localparam int NORM_STEPS  = $clog2(NORM_W);
  localparam int STEP_W      = $clog2(NORM_STEPS);
  localparam int MSB_W       = $clog2(NORM_W);
  localparam logic [NORM_W-1:0] LAT_MASK = NORM_W'((128'd1 << LAT_BITS) - 128'd1);

  // Q30 mantissa and Q8 logarithm
  localparam int MANT_W      = 31;
  localparam int FRAC_BITS   = 8;
  localparam int FRAC_STEP_W = $clog2(FRAC_BITS);
  localparam int LOG_W       = MSB_W + FRAC_BITS;

  localparam int SCALE_W     = 19;
  localparam int SCALE_SHIFT = 16;
  localparam int LEVEL_W     = LOG_W + SCALE_W - SCALE_SHIFT;

  localparam int SUM_W       = 24;
  localparam int COUNT_W     = 8;
  localparam int CEIL_W      = 16;
  localparam int PRIO_W      = 8;
  localparam int PRIO_SHIFT  = 8;
  localparam int DIV_STEP_W  = $clog2(SUM_W);
  localparam int REM_W       = COUNT_W + 1;

  // Configuration port
  localparam int CFG_W       = 19;
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_LEVEL = 2'd2;
  localparam logic [COUNT_W-1:0]   SAMPLE_COUNT_RST  = 8'd100;
  localparam logic [SCALE_W-1:0]   LEVEL_SCALE_RST   = 19'd78913;
  localparam logic [CEIL_W-1:0]    CEILING_LEVEL_RST = 16'd8192;

  // Queue between front and back (depth must be a power of two)
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [31:0] latency_us;
    logic        read_failed;
  } llp_in_t;

  typedef struct packed {
    logic [PRIO_W-1:0] priority_res;
    logic              status;
  } llp_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [SCALE_W-1:0] level_scale;
    logic [CEIL_W-1:0]  ceiling_level;
  } llp_cfg_t;

  // Classified sample as handed from front to back
  typedef struct packed {
    logic              failed;
    logic              zero;
    logic [MSB_W-1:0]  msb;
    logic [MANT_W-1:0] mant;
  } llp_entry_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_NORM,
    FR_HOLD
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_SCALE,
    BK_ACCUM,
    BK_DIVIDE,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/llp_front.sv =====
`default_nettype none

module llp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire llp_pkg::llp_in_t    item,
  output logic                     busy,
  output logic                     push_req,
  output llp_pkg::llp_entry_t      entry,
  input  wire logic                q_full
);
  import llp_pkg::*;

  fr_state_t         state, state_next;
  logic [NORM_W-1:0] norm, norm_next;
  logic [MSB_W-1:0]  lz, lz_next;
  logic [STEP_W-1:0] step, step_next;
  logic              failed, failed_next;
  logic              zero, zero_next;
  logic [NORM_W-1:0] lat_in;
  logic [NORM_W-1:0] shifted;
  logic              top_zero;

  assign lat_in = NORM_W'(item.latency_us) & LAT_MASK;

  // One binary-search step of the leading-zero count per cycle
  always_comb begin
    top_zero = 1'b0;
    shifted  = norm;
    for (int i = 0; i < NORM_STEPS; i++) begin
      if (step == STEP_W'(i)) begin
        top_zero = ((norm >> (NORM_W - (1 << i))) == '0);
        shifted  = norm << (1 << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    norm   <= norm_next;
    lz     <= lz_next;
    step   <= step_next;
    failed <= failed_next;
    zero   <= zero_next;
  end

  always_comb begin
    state_next  = state;
    norm_next   = norm;
    lz_next     = lz;
    step_next   = step;
    failed_next = failed;
    zero_next   = zero;
    unique case (state)
      FR_IDLE: begin
        if (start) begin
          failed_next = item.read_failed;
          zero_next   = (lat_in == '0);
          norm_next   = lat_in;
          lz_next     = '0;
          step_next   = STEP_W'(NORM_STEPS - 1);
          state_next  = (item.read_failed || lat_in == '0) ? FR_HOLD : FR_NORM;
        end
      end
      FR_NORM: begin
        if (top_zero) begin
          norm_next = shifted;
          lz_next   = lz + (MSB_W'(1) << step);
        end
        if (step == '0) begin
          state_next = FR_HOLD;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end
      FR_HOLD: begin
        if (!q_full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  assign busy     = (state != FR_IDLE);
  assign push_req = (state == FR_HOLD);

  always_comb begin
    entry.failed = failed;
    entry.zero   = zero;
    entry.msb    = MSB_W'(NORM_W - 1) - lz;
    entry.mant   = norm[NORM_W-1 -: MANT_W];
  end

endmodule

`default_nettype wire

// ===== rtl/llp_queue.sv =====
`default_nettype none

module llp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_req,
  input  wire llp_pkg::llp_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output llp_pkg::llp_entry_t       pop_entry,
  output logic [llp_pkg::QCNT_W-1:0] count
);
  import llp_pkg::*;

  llp_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_push   = push_req && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/llp_back.sv =====
`default_nettype none

module llp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire llp_pkg::llp_cfg_t   cfg,
  input  wire logic                pop_valid,
  input  wire llp_pkg::llp_entry_t pop_entry,
  output logic                     pop,
  output logic                     done,
  output llp_pkg::llp_out_t        result
);
  import llp_pkg::*;

  bk_state_t              state, state_next;
  logic [MANT_W-1:0]      mant, mant_next;
  logic [MSB_W-1:0]       msb, msb_next;
  logic [FRAC_BITS-1:0]   frac, frac_next;
  logic [FRAC_STEP_W-1:0] fstep, fstep_next;
  logic [LEVEL_W-1:0]     level, level_next;
  logic [COUNT_W-1:0]     seen, seen_next;
  logic [SUM_W-1:0]       sum, sum_next;
  logic [SUM_W-1:0]       quot, quot_next;
  logic [REM_W-1:0]       rem, rem_next;
  logic [DIV_STEP_W-1:0]  dstep, dstep_next;
  logic                   done_next;
  llp_out_t               result_next;

  logic [COUNT_W-1:0]     count_eff;
  logic [2*MANT_W-1:0]    sq_prod;
  logic [MANT_W:0]        sq;
  logic [LOG_W+SCALE_W-1:0] scale_prod;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_sat;
  logic [COUNT_W-1:0]     seen_inc;
  logic [REM_W-1:0]       rem_shift;
  logic [REM_W-1:0]       rem_sub;
  logic                   div_ge;
  logic [CEIL_W-1:0]      avg_clip;
  logic [CEIL_W-1:0]      diff;

  always_comb begin
    if (cfg.sample_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (cfg.sample_count > COUNT_W'(MAX_SAMPLES)) begin
      count_eff = COUNT_W'(MAX_SAMPLES);
    end else begin
      count_eff = cfg.sample_count;
    end
  end

  // Square the Q30 mantissa; the product keeps Q30 after dropping 30 bits
  assign sq_prod    = (2*MANT_W)'(mant) * (2*MANT_W)'(mant);
  assign sq         = sq_prod[2*MANT_W-1 : MANT_W-1];
  assign scale_prod = (LOG_W+SCALE_W)'({msb, frac}) * (LOG_W+SCALE_W)'(cfg.level_scale);
  assign sum_add    = (SUM_W+1)'(sum) + (SUM_W+1)'(level);
  assign sum_sat    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign seen_inc   = seen + COUNT_W'(1);
  assign rem_shift  = {rem[REM_W-2:0], quot[SUM_W-1]};
  assign div_ge     = (rem_shift >= REM_W'(count_eff));
  assign rem_sub    = rem_shift - REM_W'(count_eff);
  assign avg_clip   = (quot > SUM_W'(cfg.ceiling_level)) ? cfg.ceiling_level
                                                         : quot[CEIL_W-1:0];
  assign diff       = cfg.ceiling_level - avg_clip;
  assign pop        = (state == BK_IDLE) && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      seen  <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
      sum   <= sum_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mant   <= mant_next;
    msb    <= msb_next;
    frac   <= frac_next;
    fstep  <= fstep_next;
    level  <= level_next;
    quot   <= quot_next;
    rem    <= rem_next;
    dstep  <= dstep_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    mant_next   = mant;
    msb_next    = msb;
    frac_next   = frac;
    fstep_next  = fstep;
    level_next  = level;
    seen_next   = seen;
    sum_next    = sum;
    quot_next   = quot;
    rem_next    = rem;
    dstep_next  = dstep;
    done_next   = 1'b0;
    result_next = result;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          if (pop_entry.failed) begin
            seen_next                = '0;
            sum_next                 = '0;
            done_next                = 1'b1;
            result_next.priority_res = '0;
            result_next.status       = 1'b1;
          end else if (pop_entry.zero) begin
            level_next = '0;
            state_next = BK_ACCUM;
          end else begin
            mant_next  = pop_entry.mant;
            msb_next   = pop_entry.msb;
            frac_next  = '0;
            fstep_next = '0;
            state_next = BK_SQUARE;
          end
        end
      end
      BK_SQUARE: begin
        frac_next = {frac[FRAC_BITS-2:0], sq[MANT_W]};
        mant_next = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        if (fstep == FRAC_STEP_W'(FRAC_BITS - 1)) begin
          state_next = BK_SCALE;
        end else begin
          fstep_next = fstep + FRAC_STEP_W'(1);
        end
      end
      BK_SCALE: begin
        level_next = scale_prod[LOG_W+SCALE_W-1 : SCALE_SHIFT];
        state_next = BK_ACCUM;
      end
      BK_ACCUM: begin
        if (seen_inc >= count_eff) begin
          quot_next  = sum_sat;
          rem_next   = '0;
          dstep_next = '0;
          seen_next  = '0;
          sum_next   = '0;
          state_next = BK_DIVIDE;
        end else begin
          sum_next   = sum_sat;
          seen_next  = seen_inc;
          state_next = BK_IDLE;
        end
      end
      BK_DIVIDE: begin
        rem_next  = div_ge ? rem_sub : rem_shift;
        quot_next = {quot[SUM_W-2:0], div_ge};
        if (dstep == DIV_STEP_W'(SUM_W - 1)) begin
          state_next = BK_EMIT;
        end else begin
          dstep_next = dstep + DIV_STEP_W'(1);
        end
      end
      BK_EMIT: begin
        done_next                = 1'b1;
        result_next.priority_res = PRIO_W'(diff >> PRIO_SHIFT);
        result_next.status       = 1'b0;
        state_next               = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/latency_log_priority.sv =====
// Path priority from the logarithmic average of read latencies.
//
// Input channel: drive item (latency_us, read_failed) with start; the sample
// transfers on a rising edge where start is high and busy is low. Config
// channel: cfg_we, cfg_index, cfg_data write sample_count (0), level_scale (1)
// and ceiling_level (2), with no read-back.
// Output channel: done is high for one cycle with result (priority_res,
// status). The receiver cannot stall, so results are never held.
//
// Operation: the front end accepts a sample, runs 5 normalize steps of the
// leading-zero search (skipped for a failed read or a zero latency) and
// hands it off. A failed read passes through the queue and raises done from
// the back end's idle state. An ordinary sample occupies the back end for
// 8 squaring steps on the 31x31 squaring multiplier, scale and accumulate;
// the sample that closes a round then runs the bit-serial divider and an
// emit step. The front end takes a new sample only after handing off the
// last one, so busy holds off new samples while it normalizes or holds a
// sample for a full queue. While the 2-entry queue has room the front end
// runs ahead of the back end; once it fills, the back end sets the pace.
// Reset: config returns to 100 / 78913 / 8192, the accumulation clears and
// the queue empties; no clearing pass is needed.
`default_nettype none
`include "latency_log_priority_macros.svh"

module latency_log_priority (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire llp_pkg::llp_in_t                item,
  input  wire logic                            cfg_we,
  input  wire logic [llp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [llp_pkg::CFG_W-1:0]       cfg_data,
  output logic                                 done,
  output llp_pkg::llp_out_t                    result
);
  import llp_pkg::*;

  llp_cfg_t          cfg;
  llp_entry_t        fr_entry;
  llp_entry_t        q_entry;
  logic              fr_push_req;
  logic              q_full;
  logic              q_valid;
  logic              bk_pop;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers: take a write only on a listed index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count  <= SAMPLE_COUNT_RST;
      cfg.level_scale   <= LEVEL_SCALE_RST;
      cfg.ceiling_level <= CEILING_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT:  cfg.sample_count  <= cfg_data[COUNT_W-1:0];
        REG_LEVEL_SCALE:   cfg.level_scale   <= cfg_data[SCALE_W-1:0];
        REG_CEILING_LEVEL: cfg.ceiling_level <= cfg_data[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accept, mask and normalize the latency, flag failed/zero
  llp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .push_req (fr_push_req),
    .entry    (fr_entry),
    .q_full   (q_full)
  );

  // Short queue so the front can run ahead of the arithmetic
  llp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_req   (fr_push_req),
    .push_entry (fr_entry),
    .full       (q_full),
    .pop        (bk_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .count      (q_count)
  );

  // Back end: log2 fraction, level scale, accumulate, divide, emit
  llp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_valid),
    .pop_entry (q_entry),
    .pop       (bk_pop),
    .done      (done),
    .result    (result)
  );

  // Queue occupancy never passes its depth
  `LLP_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, q_count <= QCNT_W'(QDEPTH))
  // A sample blocked by a full queue stays offered and unchanged
  `LLP_ASSERT_NXT(a_front_holds, clk, rst, fr_push_req && q_full, fr_push_req && $stable(fr_entry))
  // A valid priority never exceeds the ceiling's integer level
  `LLP_ASSERT_IMP(a_prio_bound, clk, rst, done && !result.status, result.priority_res <= cfg.ceiling_level[CEIL_W-1:PRIO_SHIFT])

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import llp_pkg::*;

  // Result status codes
  localparam logic STATUS_VALID     = 1'b0;
  localparam logic STATUS_PATH_DOWN = 1'b1;

  localparam int ITEM_TARGET   = 1750;
  // Stop idling the input once this many samples have gone in
  localparam int QUIET_FROM    = 1500;
  localparam int RESULT_TARGET = 48;
  // Drain time after the last result: front end plus two queued samples
  // through the squaring loop, with margin
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  // Predicts the priority results from the accepted latency samples.
  class priority_tracker;
    logic [COUNT_W-1:0] count_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [CEIL_W-1:0]  ceil_reg;
    bit   [7:0]         round_samples;
    bit   [SUM_W-1:0]   round_sum;
    llp_out_t           pending_prio[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      count_reg     = SAMPLE_COUNT_RST;
      scale_reg     = LEVEL_SCALE_RST;
      ceil_reg      = CEILING_LEVEL_RST;
      round_samples = '0;
      round_sum     = '0;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SAMPLE_COUNT:  count_reg = data[COUNT_W-1:0];
        REG_LEVEL_SCALE:   scale_reg = data[SCALE_W-1:0];
        REG_CEILING_LEVEL: ceil_reg  = data[CEIL_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(llp_in_t s);
      bit [63:0] lat, mant, frac, level, total, eff, avg, prio;
      int        msb;
      llp_out_t  r;
      if (s.read_failed) begin
        round_samples  = '0;
        round_sum      = '0;
        r.priority_res = '0;
        r.status       = STATUS_PATH_DOWN;
        pending_prio.push_back(r);
        return;
      end
      lat = 64'(s.latency_us & LAT_MASK);
      if (lat != 0) begin
        // Q8 log2: integer part from the top set bit, fraction by squaring
        msb = 0;
        for (int i = 0; i < 64; i++)
          if (lat[i]) msb = i;
        mant = (msb >= 30) ? (lat >> (msb - 30)) : (lat << (30 - msb));
        frac = 0;
        repeat (FRAC_BITS) begin
          mant = (mant * mant) >> 30;
          frac = frac << 1;
          if (mant >= 64'h8000_0000) begin
            frac = frac | 64'd1;
            mant = mant >> 1;
          end
        end
        level = (((64'(msb) << 8) | frac) * 64'(scale_reg)) >> SCALE_SHIFT;
        total = 64'(round_sum) + level;
        round_sum = (total > 64'hFF_FFFF) ? 24'hFF_FFFF : total[SUM_W-1:0];
      end
      round_samples = round_samples + 8'd1;

      eff = (count_reg == 0) ? 64'd1 :
            (count_reg > MAX_SAMPLES) ? 64'(MAX_SAMPLES) : 64'(count_reg);
      // Emit as soon as the round reaches or passes the count
      if (64'(round_samples) < eff) return;

      avg = 64'(round_sum) / eff;
      if (avg > 64'(ceil_reg)) avg = 64'(ceil_reg);
      prio = (64'(ceil_reg) - avg) >> PRIO_SHIFT;
      r.priority_res = prio[PRIO_W-1:0];
      r.status       = STATUS_VALID;
      pending_prio.push_back(r);
      round_samples = '0;
      round_sum     = '0;
    endfunction

    function void match_result(llp_out_t got);
      llp_out_t want;
      bit       bad;
      results_seen++;
      if (pending_prio.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: priority_res=%0d status=%0d",
                   $realtime, got.priority_res, got.status);
        return;
      end
      want = pending_prio.pop_front();
      bad  = 1'b0;
      if (got.priority_res !== want.priority_res) bad = 1'b1;
      if (got.status !== want.status) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: priority_res exp %0d got %0d, status exp %0d got %0d",
                   $realtime, want.priority_res, got.priority_res,
                   want.status, got.status);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  llp_in_t              item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  llp_out_t             result;

  priority_tracker tracker;
  int              n_taken;
  int              n_sent;
  int              cycles;

  latency_log_priority dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Monitor both channels at the rising edge. Inputs move on the falling
  // edge, so what is seen here is exactly what the block sees.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        tracker.take_sample(item);
        n_taken++;
      end
      if (done) tracker.match_result(result);
    end
  end

  // Drive one sample and hold it until its transfer. Called at a falling
  // edge; returns at the falling edge after the transfer, with start still
  // high so a back-to-back sample follows without a drop in start.
  task automatic feed(input logic [31:0] lat, input logic failed);
    llp_in_t s;
    int      taken_mark;
    // Insert an idle burst now and then, except near the end of the run
    if (n_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s.latency_us  = lat;
    s.read_failed = failed;
    start  <= 1'b1;
    item   <= s;
    taken_mark = n_taken;
    do @(negedge clk); while (n_taken == taken_mark);
    n_sent++;
  endtask

  // Drop start, let every expected result come back, give queued samples
  // that close no round time to finish, then write all three registers.
  task automatic program_regs(input logic [COUNT_W-1:0] cnt,
                              input logic [SCALE_W-1:0] scl,
                              input logic [CEIL_W-1:0]  ceil_v);
    start <= 1'b0;
    while (tracker.pending_prio.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SAMPLE_COUNT;
    cfg_data  <= CFG_W'(cnt);
    tracker.set_reg(REG_SAMPLE_COUNT, CFG_W'(cnt));
    @(negedge clk);
    cfg_index <= REG_LEVEL_SCALE;
    cfg_data  <= CFG_W'(scl);
    tracker.set_reg(REG_LEVEL_SCALE, CFG_W'(scl));
    @(negedge clk);
    cfg_index <= REG_CEILING_LEVEL;
    cfg_data  <= CFG_W'(ceil_v);
    tracker.set_reg(REG_CEILING_LEVEL, CFG_W'(ceil_v));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] cnt;
    logic [SCALE_W-1:0] scl;
    logic [CEIL_W-1:0]  ceil_v;
    logic [31:0]        lat;
    int                 eff;
    int                 burst;
    int                 pick;

    tracker   = new();
    n_taken   = 0;
    n_sent    = 0;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A zero count acts as one, so every sample closes a round. Hit the
    // latency extremes and a failed read carrying an all-ones latency.
    program_regs(8'd0, 19'd78913, 16'd8192);
    feed(32'd0, 1'b0);
    feed(32'd1, 1'b0);
    feed(32'd2, 1'b0);
    feed(32'd3, 1'b0);
    feed(32'd100000000, 1'b0);
    feed(32'h7FFF_FFFF, 1'b0);
    feed(32'h8000_0000, 1'b0);
    feed(32'hFFFF_FFFF, 1'b0);
    feed(32'hFFFF_FFFF, 1'b1);

    // Maximum scale with a zero ceiling: the average always lands above
    // the ceiling. A failed read mid-round throws the partial round away.
    program_regs(8'd4, 19'h7FFFF, 16'd0);
    feed(32'hFFFF_FFFF, 1'b0);
    feed(32'h0001_0000, 1'b0);
    feed(32'd0, 1'b1);
    feed(32'hFFFF_FFFF, 1'b0);
    feed(32'hFFFF_FFFF, 1'b0);
    feed(32'hFFFF_FFFF, 1'b0);
    feed(32'hFFFF_FFFF, 1'b0);

    // Lower the count mid-round: three samples pending against a count of
    // five, then a count of two makes the next sample close the round.
    program_regs(8'd5, 19'd19728, 16'hFFFF);
    feed(32'd7, 1'b0);
    feed(32'd5000, 1'b0);
    feed(32'd0, 1'b0);
    program_regs(8'd2, 19'd476611, 16'd49479);
    feed(32'd123456, 1'b0);

    // Random phases: fresh settings each time, mostly clean rounds of
    // random latencies with the occasional failed read as noise.
    while (n_sent < ITEM_TARGET || tracker.results_seen < RESULT_TARGET) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0, 1, 2, 3, 4: cnt = 8'($urandom_range(1, 12));
        5:             cnt = 8'd0;
        6:             cnt = 8'($urandom_range(13, 40));
        7:             cnt = 8'($urandom_range(20, 200));
        8:             cnt = ($urandom_range(0, 1) == 0) ? 8'd200 : 8'd100;
        9:             cnt = 8'($urandom_range(201, 255));
        default:       cnt = 8'($urandom_range(1, 6));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       scl = 19'd19728;
        1:       scl = 19'd476611;
        2:       scl = ($urandom_range(0, 1) == 0) ? 19'd0 : 19'h7FFFF;
        3:       scl = 19'($urandom);
        default: scl = 19'($urandom_range(19728, 476611));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       ceil_v = 16'd2048;
        1:       ceil_v = 16'd49479;
        2:       ceil_v = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        3:       ceil_v = 16'($urandom);
        default: ceil_v = 16'($urandom_range(2048, 49479));
      endcase
      program_regs(cnt, scl, ceil_v);

      eff = (cnt == 0) ? 1 : (cnt > MAX_SAMPLES) ? MAX_SAMPLES : int'(cnt);
      // Leave partial rounds behind now and then; the next phase picks
      // them up under its own count.
      burst = $urandom_range(eff, 2 * eff + 8);
      repeat (burst) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0:       lat = 32'd0;
          1:       lat = ($urandom_range(0, 1) == 0) ? 32'd1 : 32'hFFFF_FFFF;
          default: lat = $urandom >> $urandom_range(0, 31);
        endcase
        feed(lat, ($urandom_range(0, 39) == 0));
      end
    end

    // Drain: wait for the last results, then watch for stray ones.
    start <= 1'b0;
    while (tracker.pending_prio.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (tracker.mismatches == 0 && tracker.pending_prio.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
